>>> sv/ucdp_pkg.sv
// Shared types and constants for the USB configuration descriptor parser.
// Used by ucdp_ctrl, ucdp_datapath and usb_config_descriptor_parser.
`timescale 1ns / 1ps
`default_nettype none

package ucdp_pkg;

   // Record kinds on the result channel
   localparam logic [2:0] REC_FUNCTION    = 3'd0;
   localparam logic [2:0] REC_ALTERNATE   = 3'd1;
   localparam logic [2:0] REC_ENDPOINT    = 3'd2;
   localparam logic [2:0] REC_END_VALID   = 3'd3;
   localparam logic [2:0] REC_END_INVALID = 3'd4;

   // Descriptor types
   localparam logic [7:0] DT_CONFIG    = 8'h02;
   localparam logic [7:0] DT_INTERFACE = 8'h04;
   localparam logic [7:0] DT_ENDPOINT  = 8'h05;
   localparam logic [7:0] DT_IAD       = 8'h0B;

   // Minimum descriptor lengths
   localparam logic [7:0] LEN_MIN       = 8'd2;
   localparam logic [7:0] LEN_CONFIG    = 8'd9;
   localparam logic [7:0] LEN_IAD       = 8'd8;
   localparam logic [7:0] LEN_INTERFACE = 8'd9;
   localparam logic [7:0] LEN_ENDPOINT  = 8'd7;

   localparam logic [15:0] HEADER_BYTES = 16'd9;
   localparam logic [15:0] OFFSET_LIMIT = 16'hFFFF;
   localparam logic [1:0]  XFER_MASK    = 2'b11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SEARCH,
      ST_FINISH,
      ST_FUNC2,
      ST_END
   } ucdp_state_type;

   typedef enum logic [1:0] {
      FK_NONE,
      FK_ASSOC,
      FK_IFACE,
      FK_EP
   } ucdp_fkind_type;

   typedef struct packed {
      logic load;
      logic step;
      logic search;
      logic finish;
      logic func2;
      logic endrec;
   } ucdp_cmd_type;

   typedef struct packed {
      ucdp_fkind_type fkind;
      logic           fin;
      logic           search_done;
      logic           need_func2;
      logic           out_free;
   } ucdp_status_type;

endpackage

`default_nettype wire

>>> sv/ucdp_ctrl.sv
// Controller state machine of the descriptor parser.
// Depends on ucdp_pkg; drives commands into ucdp_datapath.
`timescale 1ns / 1ps
`default_nettype none

module ucdp_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  ucdp_pkg::ucdp_status_type status,
   output ucdp_pkg::ucdp_cmd_type    cmd
);
   import ucdp_pkg::*;

   ucdp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            unique case (status.fkind)
               FK_IFACE:        state_in = ST_SEARCH;
               FK_ASSOC, FK_EP: state_in = ST_FINISH;
               default:         state_in = status.fin ? ST_END : ST_IDLE;
            endcase
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.search_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take a record
            if (status.out_free) begin
               cmd.finish = 1'b1;
               priority if (status.need_func2) state_in = ST_FUNC2;
               else if (status.fin)            state_in = ST_END;
               else                            state_in = ST_IDLE;
            end
         end
         ST_FUNC2: begin
            if (status.out_free) begin
               cmd.func2 = 1'b1;
               state_in  = status.fin ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            if (status.out_free) begin
               cmd.endrec = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

>>> sv/ucdp_datapath.sv
// Datapath of the descriptor parser: parse state, field captures, interface
// and function tables, table search and the result register. Uses ucdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucdp_datapath #(
   parameter int MAX_INTERFACES = 32,
   parameter int MAX_FUNCTIONS  = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  ucdp_pkg::ucdp_cmd_type    cmd,
   output ucdp_pkg::ucdp_status_type status,
   input  wire  [7:0]                req_data_byte,
   input  wire                       req_final_byte,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic [2:0]                rsp_rec_kind,
   output logic [7:0]                rsp_interface_number,
   output logic [7:0]                rsp_count_or_config,
   output logic [7:0]                rsp_alt_setting,
   output logic [7:0]                rsp_base_class,
   output logic [7:0]                rsp_sub_class,
   output logic [7:0]                rsp_proto,
   output logic                      rsp_new_interface,
   output logic [7:0]                rsp_ep_address,
   output logic [1:0]                rsp_transfer_type,
   output logic [15:0]               rsp_max_packet,
   output logic                      rsp_run_last
);
   import ucdp_pkg::*;

   localparam int IW  = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
   localparam int FW  = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
   localparam int ICW = $clog2(MAX_INTERFACES + 1);
   localparam int FCW = $clog2(MAX_FUNCTIONS + 1);
   localparam int SW  = (ICW > FCW) ? ICW : FCW;

   // tables
   logic [7:0]  iface_mem [MAX_INTERFACES];
   logic [15:0] func_mem  [MAX_FUNCTIONS];
   logic [7:0]  cap_ff    [8];

   logic [7:0]     byte_ff, byte_in;
   logic           fin_ff, fin_in;
   logic [15:0]    offset_ff, offset_in;
   logic [15:0]    declared_ff, declared_in;
   logic [15:0]    start_ff, start_in;
   logic [7:0]     length_ff, length_in;
   logic [7:0]     kind_ff, kind_in;
   logic [7:0]     config_ff, config_in;
   logic [ICW-1:0] icount_ff, icount_in;
   logic [FCW-1:0] fcount_ff, fcount_in;
   logic           alt_valid_ff, alt_valid_in;
   logic [7:0]     alt_if_ff, alt_if_in;
   logic [7:0]     alt_set_ff, alt_set_in;
   logic           err_ff, err_in;
   ucdp_fkind_type fkind_ff, fkind_in;
   logic [SW-1:0]  idx_ff, idx_in;
   logic           rdv_i_ff, rdv_i_in;
   logic           rdv_f_ff, rdv_f_in;
   logic           known_ff, known_in;
   logic           covered_ff, covered_in;
   logic [7:0]     rd_i_ff;
   logic [15:0]    rd_f_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     kind_o_ff, kind_o_in;
   logic [7:0]     ifn_o_ff, ifn_o_in;
   logic [7:0]     cnt_o_ff, cnt_o_in;
   logic [7:0]     alt_o_ff, alt_o_in;
   logic [7:0]     cls_o_ff, cls_o_in;
   logic [7:0]     sub_o_ff, sub_o_in;
   logic [7:0]     pro_o_ff, pro_o_in;
   logic           newi_o_ff, newi_o_in;
   logic [7:0]     epa_o_ff, epa_o_in;
   logic [1:0]     tt_o_ff, tt_o_in;
   logic [15:0]    mp_o_ff, mp_o_in;
   logic           last_o_ff, last_o_in;

   logic           cap_we;
   logic [2:0]     cap_idx;
   logic           imem_we, fmem_we;
   logic [7:0]     imem_wdata;
   logic [15:0]    fmem_wdata;
   logic [IW-1:0]  imem_raddr;
   logic [FW-1:0]  fmem_raddr;

   logic [15:0]    pos, rel, rel_m2;
   logic           over, err_now, short_desc;
   logic [7:0]     kind_eff;
   ucdp_fkind_type fkind_step;
   logic [SW-1:0]  limit;
   logic           search_done;
   logic           ifull, ffull, iface_full, need_func2;
   logic           covers;
   logic           end_ok;
   logic           emit;
   logic           out_free;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign limit       = (SW'(icount_ff) > SW'(fcount_ff)) ? SW'(icount_ff) : SW'(fcount_ff);
   assign search_done = (idx_ff == limit);
   assign ifull       = (icount_ff == ICW'(MAX_INTERFACES));
   assign ffull       = (fcount_ff == FCW'(MAX_FUNCTIONS));
   assign iface_full  = (!known_ff && ifull) || (!covered_ff && ffull);
   assign need_func2  = (fkind_ff == FK_IFACE) && !iface_full && !covered_ff;
   assign covers      = (cap_ff[0] >= rd_f_ff[15:8]) &&
                        ({1'b0, cap_ff[0]} < ({1'b0, rd_f_ff[15:8]} + {1'b0, rd_f_ff[7:0]}));
   assign end_ok      = !err_ff && (offset_ff > HEADER_BYTES) && (declared_ff == offset_ff) &&
                        ({1'b0, offset_ff} == ({1'b0, start_ff} + {9'h000, length_ff}));

   assign imem_raddr = (idx_ff < SW'(MAX_INTERFACES)) ? IW'(idx_ff) : '0;
   assign fmem_raddr = (idx_ff < SW'(MAX_FUNCTIONS)) ? FW'(idx_ff) : '0;

   // per-byte decode of the registered request
   assign pos     = offset_ff;
   assign over    = (pos == OFFSET_LIMIT);
   assign err_now = err_ff || over;
   assign rel     = pos - start_ff;
   assign rel_m2  = rel - 16'd2;
   assign cap_idx = rel_m2[2:0];

   always_comb begin
      kind_eff   = (rel == 16'd1) ? byte_ff : kind_ff;
      short_desc = (rel == 16'd1) &&
                   ((byte_ff == DT_IAD && length_ff < LEN_IAD) ||
                    (byte_ff == DT_INTERFACE && length_ff < LEN_INTERFACE) ||
                    (byte_ff == DT_ENDPOINT && length_ff < LEN_ENDPOINT));
      fkind_step = FK_NONE;
      if (!err_now && pos >= HEADER_BYTES && rel < {8'h00, length_ff} && !short_desc &&
          rel >= 16'd1 && (rel + 16'd1) == {8'h00, length_ff}) begin
         priority if (kind_eff == DT_IAD)       fkind_step = FK_ASSOC;
         else if (kind_eff == DT_INTERFACE)     fkind_step = FK_IFACE;
         else if (kind_eff == DT_ENDPOINT)      fkind_step = FK_EP;
         else                                   fkind_step = FK_NONE;
      end
   end

   always_comb begin
      status.fkind       = fkind_step;
      status.fin         = fin_ff;
      status.search_done = search_done;
      status.need_func2  = need_func2;
      status.out_free    = out_free;
   end

   always_comb begin
      byte_in      = byte_ff;
      fin_in       = fin_ff;
      offset_in    = offset_ff;
      declared_in  = declared_ff;
      start_in     = start_ff;
      length_in    = length_ff;
      kind_in      = kind_ff;
      config_in    = config_ff;
      icount_in    = icount_ff;
      fcount_in    = fcount_ff;
      alt_valid_in = alt_valid_ff;
      alt_if_in    = alt_if_ff;
      alt_set_in   = alt_set_ff;
      err_in       = err_ff;
      fkind_in     = fkind_ff;
      idx_in       = idx_ff;
      rdv_i_in     = rdv_i_ff;
      rdv_f_in     = rdv_f_ff;
      known_in     = known_ff;
      covered_in   = covered_ff;
      cap_we       = 1'b0;
      imem_we      = 1'b0;
      fmem_we      = 1'b0;
      imem_wdata   = cap_ff[0];
      fmem_wdata   = {cap_ff[0], cap_ff[1]};
      emit         = 1'b0;
      kind_o_in    = REC_FUNCTION;
      ifn_o_in     = '0;
      cnt_o_in     = '0;
      alt_o_in     = '0;
      cls_o_in     = '0;
      sub_o_in     = '0;
      pro_o_in     = '0;
      newi_o_in    = 1'b0;
      epa_o_in     = '0;
      tt_o_in      = '0;
      mp_o_in      = '0;
      last_o_in    = 1'b0;

      if (cmd.load) begin
         byte_in = req_data_byte;
         fin_in  = req_final_byte;
      end

      if (cmd.step) begin
         if (over) begin
            err_in = 1'b1;
         end else begin
            offset_in = offset_ff + 16'd1;
         end
         fkind_in   = fkind_step;
         idx_in     = '0;
         rdv_i_in   = 1'b0;
         rdv_f_in   = 1'b0;
         known_in   = 1'b0;
         covered_in = 1'b0;
         if (!err_now) begin
            if (pos < HEADER_BYTES) begin
               priority if (pos == 16'd0) begin
                  start_in  = '0;
                  length_in = byte_ff;
                  kind_in   = DT_CONFIG;
                  if (byte_ff < LEN_CONFIG) err_in = 1'b1;
               end else if (pos == 16'd1) begin
                  if (byte_ff != DT_CONFIG) err_in = 1'b1;
               end else if (pos == 16'd2) begin
                  declared_in = {8'h00, byte_ff};
               end else if (pos == 16'd3) begin
                  declared_in = {byte_ff, declared_ff[7:0]};
               end else if (pos == 16'd5) begin
                  config_in = byte_ff;
               end
            end else if (rel >= {8'h00, length_ff}) begin
               // length byte of the next descriptor
               start_in  = pos;
               length_in = byte_ff;
               kind_in   = '0;
               if (byte_ff < LEN_MIN) err_in = 1'b1;
            end else if (short_desc) begin
               kind_in = byte_ff;
               err_in  = 1'b1;
            end else begin
               kind_in = kind_eff;
               if (rel >= 16'd2 && rel < 16'd10) cap_we = 1'b1;
            end
         end
      end

      if (cmd.search) begin
         rdv_i_in = idx_ff < SW'(icount_ff);
         rdv_f_in = idx_ff < SW'(fcount_ff);
         if (rdv_i_ff && rd_i_ff == cap_ff[0]) known_in = 1'b1;
         if (rdv_f_ff && covers) covered_in = 1'b1;
         if (!search_done) idx_in = idx_ff + SW'(1);
      end

      if (cmd.finish) begin
         last_o_in = !need_func2 && !fin_ff;
         unique case (fkind_ff)
            FK_ASSOC: begin
               if (ffull) begin
                  err_in = 1'b1;
               end else begin
                  fmem_we      = 1'b1;
                  fcount_in    = fcount_ff + FCW'(1);
                  alt_valid_in = 1'b0;
                  alt_if_in    = '0;
                  alt_set_in   = '0;
                  emit         = 1'b1;
                  kind_o_in    = REC_FUNCTION;
                  ifn_o_in     = cap_ff[0];
                  cnt_o_in     = cap_ff[1];
                  cls_o_in     = cap_ff[2];
                  sub_o_in     = cap_ff[3];
                  pro_o_in     = cap_ff[4];
               end
            end
            FK_IFACE: begin
               if (iface_full) begin
                  err_in = 1'b1;
               end else begin
                  if (!known_ff) begin
                     imem_we   = 1'b1;
                     icount_in = icount_ff + ICW'(1);
                  end
                  alt_valid_in = 1'b1;
                  alt_if_in    = cap_ff[0];
                  alt_set_in   = cap_ff[1];
                  emit         = 1'b1;
                  kind_o_in    = REC_ALTERNATE;
                  ifn_o_in     = cap_ff[0];
                  alt_o_in     = cap_ff[1];
                  cls_o_in     = cap_ff[3];
                  sub_o_in     = cap_ff[4];
                  pro_o_in     = cap_ff[5];
                  newi_o_in    = !known_ff;
               end
            end
            FK_EP: begin
               if (!alt_valid_ff) begin
                  err_in = 1'b1;
               end else begin
                  emit      = 1'b1;
                  kind_o_in = REC_ENDPOINT;
                  ifn_o_in  = alt_if_ff;
                  alt_o_in  = alt_set_ff;
                  epa_o_in  = cap_ff[0];
                  tt_o_in   = cap_ff[1][1:0] & XFER_MASK;
                  mp_o_in   = {cap_ff[3], cap_ff[2]};
               end
            end
            default: ;
         endcase
      end

      if (cmd.func2) begin
         // one-interface function for an interface no association covers
         fmem_we    = 1'b1;
         fmem_wdata = {cap_ff[0], 8'd1};
         fcount_in  = fcount_ff + FCW'(1);
         emit       = 1'b1;
         kind_o_in  = REC_FUNCTION;
         ifn_o_in   = cap_ff[0];
         cnt_o_in   = 8'd1;
         cls_o_in   = cap_ff[3];
         sub_o_in   = cap_ff[4];
         pro_o_in   = cap_ff[5];
         last_o_in  = !fin_ff;
      end

      if (cmd.endrec) begin
         emit         = 1'b1;
         kind_o_in    = end_ok ? REC_END_VALID : REC_END_INVALID;
         cnt_o_in     = config_ff;
         last_o_in    = 1'b1;
         offset_in    = '0;
         declared_in  = '0;
         start_in     = '0;
         length_in    = '0;
         kind_in      = '0;
         config_in    = '0;
         icount_in    = '0;
         fcount_in    = '0;
         alt_valid_in = 1'b0;
         alt_if_in    = '0;
         alt_set_in   = '0;
         err_in       = 1'b0;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         declared_ff  <= '0;
         start_ff     <= '0;
         length_ff    <= '0;
         kind_ff      <= '0;
         config_ff    <= '0;
         icount_ff    <= '0;
         fcount_ff    <= '0;
         alt_valid_ff <= 1'b0;
         alt_if_ff    <= '0;
         alt_set_ff   <= '0;
         err_ff       <= 1'b0;
         fkind_ff     <= FK_NONE;
         idx_ff       <= '0;
         rdv_i_ff     <= 1'b0;
         rdv_f_ff     <= 1'b0;
         known_ff     <= 1'b0;
         covered_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         declared_ff  <= declared_in;
         start_ff     <= start_in;
         length_ff    <= length_in;
         kind_ff      <= kind_in;
         config_ff    <= config_in;
         icount_ff    <= icount_in;
         fcount_ff    <= fcount_in;
         alt_valid_ff <= alt_valid_in;
         alt_if_ff    <= alt_if_in;
         alt_set_ff   <= alt_set_in;
         err_ff       <= err_in;
         fkind_ff     <= fkind_in;
         idx_ff       <= idx_in;
         rdv_i_ff     <= rdv_i_in;
         rdv_f_ff     <= rdv_f_in;
         known_ff     <= known_in;
         covered_ff   <= covered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      fin_ff  <= fin_in;
      if (cap_we) cap_ff[cap_idx] <= byte_ff;
      if (emit) begin
         kind_o_ff <= kind_o_in;
         ifn_o_ff  <= ifn_o_in;
         cnt_o_ff  <= cnt_o_in;
         alt_o_ff  <= alt_o_in;
         cls_o_ff  <= cls_o_in;
         sub_o_ff  <= sub_o_in;
         pro_o_ff  <= pro_o_in;
         newi_o_ff <= newi_o_in;
         epa_o_ff  <= epa_o_in;
         tt_o_ff   <= tt_o_in;
         mp_o_ff   <= mp_o_in;
         last_o_ff <= last_o_in;
      end
   end

   always_ff @(posedge clock) begin
      if (imem_we) iface_mem[IW'(icount_ff)] <= imem_wdata;
      rd_i_ff <= iface_mem[imem_raddr];
   end

   always_ff @(posedge clock) begin
      if (fmem_we) func_mem[FW'(fcount_ff)] <= fmem_wdata;
      rd_f_ff <= func_mem[fmem_raddr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_rec_kind         = kind_o_ff;
   assign rsp_interface_number = ifn_o_ff;
   assign rsp_count_or_config  = cnt_o_ff;
   assign rsp_alt_setting      = alt_o_ff;
   assign rsp_base_class       = cls_o_ff;
   assign rsp_sub_class        = sub_o_ff;
   assign rsp_proto            = pro_o_ff;
   assign rsp_new_interface    = newi_o_ff;
   assign rsp_ep_address       = epa_o_ff;
   assign rsp_transfer_type    = tt_o_ff;
   assign rsp_max_packet       = mp_o_ff;
   assign rsp_run_last         = last_o_ff;

`ifndef NO_ASSERTIONS
   a_icount_bound: assert property (@(posedge clock) disable iff (reset)
      icount_ff <= ICW'(MAX_INTERFACES))
      else $error("interface count beyond table size");

   a_fcount_bound: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= FCW'(MAX_FUNCTIONS))
      else $error("function count beyond table size");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("record overwrites a pending result");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.endrec |=> (icount_ff == '0 && fcount_ff == '0 && !err_ff && offset_ff == '0))
      else $error("parse state not cleared after end record");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.search |-> idx_ff <= limit)
      else $error("table search ran past its limit");
`endif

endmodule

`default_nettype wire

>>> sv/usb_config_descriptor_parser.sv
// Top level of the USB configuration descriptor parser.
// Instantiates ucdp_ctrl and ucdp_datapath; types from ucdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes a configuration descriptor one byte per request, checks the header
// and emits function, alternate and endpoint records as descriptors close,
// plus an end record (valid or invalid, with the configuration value) on
// the byte marked final. A plain byte is accepted, then parsed in the step
// state; no new byte is taken until the last one is done. A closing
// association or endpoint descriptor adds the finish state; a closing
// interface descriptor adds a search of both table memories before that,
// plus the func2 state when it also creates a function. The final byte
// adds the end state. Each record waits until the result register is free.
module usb_config_descriptor_parser #(
   parameter int MAX_INTERFACES = 32,
   parameter int MAX_FUNCTIONS  = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_final_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_rec_kind,
   output logic [7:0]  rsp_interface_number,
   output logic [7:0]  rsp_count_or_config,
   output logic [7:0]  rsp_alt_setting,
   output logic [7:0]  rsp_base_class,
   output logic [7:0]  rsp_sub_class,
   output logic [7:0]  rsp_proto,
   output logic        rsp_new_interface,
   output logic [7:0]  rsp_ep_address,
   output logic [1:0]  rsp_transfer_type,
   output logic [15:0] rsp_max_packet,
   output logic        rsp_run_last
);
   import ucdp_pkg::*;

   ucdp_cmd_type    cmd;
   ucdp_status_type status;

   ucdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ucdp_datapath #(
      .MAX_INTERFACES (MAX_INTERFACES),
      .MAX_FUNCTIONS  (MAX_FUNCTIONS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_data_byte        (req_data_byte),
      .req_final_byte       (req_final_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_rec_kind         (rsp_rec_kind),
      .rsp_interface_number (rsp_interface_number),
      .rsp_count_or_config  (rsp_count_or_config),
      .rsp_alt_setting      (rsp_alt_setting),
      .rsp_base_class       (rsp_base_class),
      .rsp_sub_class        (rsp_sub_class),
      .rsp_proto            (rsp_proto),
      .rsp_new_interface    (rsp_new_interface),
      .rsp_ep_address       (rsp_ep_address),
      .rsp_transfer_type    (rsp_transfer_type),
      .rsp_max_packet       (rsp_max_packet),
      .rsp_run_last         (rsp_run_last)
   );

endmodule

`default_nettype wire
